// ===== design/dpi_pkg.sv =====
// ----------------------------------------------------------------------------
// dpi_pkg
// Shared types, constants and field helpers for the delayed pose interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package dpi_pkg;

	localparam int DEFAULT_HISTORY_DEPTH = 64;

	localparam int TIME_W  = 32;
	localparam int DELAY_W = 20;
	localparam int DT_W    = 16;
	localparam int POS_W   = 24;
	localparam int SCL_W   = 16;

	// ages stay below delay + keep window, which fits 21 bits
	localparam int NUM_W   = 21;
	localparam int MAG_W   = 24;
	localparam int ACC_W   = MAG_W + NUM_W;
	localparam int QUO_W   = 25;
	localparam int REM_W   = NUM_W + 1;

	localparam logic [TIME_W-1:0] KEEP_EXTRA_US = 32'd200000;
	localparam logic [TIME_W-1:0] MIN_DELAY_US  = 32'd100;
	localparam logic [TIME_W-1:0] MIN_GAP_US    = 32'd10;

	localparam int NUM_FIELDS = 5;

	typedef enum logic [2:0] {
		FLD_X   = 3'd0,
		FLD_Y   = 3'd1,
		FLD_ROT = 3'd2,
		FLD_SX  = 3'd3,
		FLD_SY  = 3'd4
	} fld_t;

	typedef struct packed {
		logic [TIME_W-1:0]       t;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] rot;
		logic signed [SCL_W-1:0] sx;
		logic signed [SCL_W-1:0] sy;
	} snap_t;

	// one pose field of an entry, sign extended to position width
	function automatic logic signed [POS_W-1:0] entry_field(snap_t e, fld_t f);
		logic signed [POS_W-1:0] v;
		unique case (f)
			FLD_X:   v = e.x;
			FLD_Y:   v = e.y;
			FLD_ROT: v = e.rot;
			FLD_SX:  v = POS_W'(e.sx);
			FLD_SY:  v = POS_W'(e.sy);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== design/dpi_if.sv =====
// ----------------------------------------------------------------------------
// dpi_in_if / dpi_out_if
// Valid/ready channels carrying pose items in and shadow results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpi_in_if;
	logic                              valid;
	logic                              ready;
	logic [dpi_pkg::DT_W-1:0]          dt_us;
	logic signed [dpi_pkg::POS_W-1:0]  pos_x;
	logic signed [dpi_pkg::POS_W-1:0]  pos_y;
	logic signed [dpi_pkg::POS_W-1:0]  rotation_in;
	logic signed [dpi_pkg::SCL_W-1:0]  scale_x_in;
	logic signed [dpi_pkg::SCL_W-1:0]  scale_y_in;

	modport source (output valid, dt_us, pos_x, pos_y, rotation_in, scale_x_in,
		scale_y_in, input ready);
	modport sink (input valid, dt_us, pos_x, pos_y, rotation_in, scale_x_in,
		scale_y_in, output ready);
endinterface

interface dpi_out_if;
	logic                              valid;
	logic                              ready;
	logic                              shadow_valid;
	logic signed [dpi_pkg::POS_W-1:0]  shadow_x;
	logic signed [dpi_pkg::POS_W-1:0]  shadow_y;
	logic signed [dpi_pkg::POS_W-1:0]  shadow_rotation;
	logic signed [dpi_pkg::SCL_W-1:0]  shadow_scale_x;
	logic signed [dpi_pkg::SCL_W-1:0]  shadow_scale_y;

	modport source (output valid, shadow_valid, shadow_x, shadow_y, shadow_rotation,
		shadow_scale_x, shadow_scale_y, input ready);
	modport sink (input valid, shadow_valid, shadow_x, shadow_y, shadow_rotation,
		shadow_scale_x, shadow_scale_y, output ready);
endinterface

`default_nettype wire

// ===== design/delayed_pose_interpolator.sv =====
// ----------------------------------------------------------------------------
// delayed_pose_interpolator
// Keeps a ring of timestamped poses and outputs the pose interpolated at
// current time minus a programmable delay.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      dt_us, pos_x, pos_y, rotation_in, scale_x/y_in
//  out_ch    out  valid/ready      shadow_valid, shadow_x/y, rotation, scale_x/y
//  cfg       in   cfg_we           cfg_wdata = delay_us
//
//  one item at a time; the ring sits in one single-port-read memory.
//  per item: prune stale entries, scan pairs for the bracket, then when
//  interpolating, 5 fields x (21-step multiply + 25-step divide).
//  reset clears the clock, ring pointers and count; ring data needs no reset.
//  the result sits in an output register; a stalled output only holds the
//  finished next result until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module delayed_pose_interpolator #(
	parameter int HISTORY_DEPTH = dpi_pkg::DEFAULT_HISTORY_DEPTH
) (
	input  wire                        clk,
	input  wire                        arst_n,
	dpi_in_if.sink                     in_ch,
	dpi_out_if.source                  out_ch,
	input  wire                        cfg_we,
	input  wire [dpi_pkg::DELAY_W-1:0] cfg_wdata
);

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(HISTORY_DEPTH);

	typedef enum logic [10:0] {
		S_IDLE      = 11'b00000000001,
		S_PRUNE_RD  = 11'b00000000010,
		S_PRUNE_CHK = 11'b00000000100,
		S_SCAN_RD   = 11'b00000001000,
		S_SCAN_CHK  = 11'b00000010000,
		S_LERP_SET  = 11'b00000100000,
		S_MUL       = 11'b00001000000,
		S_DIV_SET   = 11'b00010000000,
		S_DIV       = 11'b00100000000,
		S_FIN       = 11'b01000000000,
		S_OUT       = 11'b10000000000
	} state_t;

	state_t state_q;

	dpi_pkg::snap_t mem [HISTORY_DEPTH];
	dpi_pkg::snap_t rd_q, prev_q, next_q, first_q;

	logic [dpi_pkg::DELAY_W-1:0] delay_q;
	logic [dpi_pkg::TIME_W-1:0]  elapsed_q;
	logic [AW-1:0]               oldest_q, ptr_q;
	logic [CW-1:0]               count_q, idx_q;

	logic [dpi_pkg::NUM_W-1:0]       num_q, den_q;
	logic [dpi_pkg::MAG_W-1:0]       mag_q;
	logic                            neg_q;
	logic signed [dpi_pkg::POS_W-1:0] p_q;
	logic [dpi_pkg::ACC_W-1:0]       acc_q;
	logic [dpi_pkg::REM_W-1:0]       rem_q;
	logic [dpi_pkg::QUO_W-1:0]       dvd_q, quo_q;
	logic [4:0]                      cnt_q;
	dpi_pkg::fld_t                   fld_q;
	logic signed [dpi_pkg::POS_W-1:0] res_q [dpi_pkg::NUM_FIELDS];
	logic                            res_vld_q;

	logic                             ov_q, osv_q;
	logic signed [dpi_pkg::POS_W-1:0] ox_q, oy_q, orot_q;
	logic signed [dpi_pkg::SCL_W-1:0] osx_q, osy_q;

	function automatic logic [AW-1:0] inc_idx(logic [AW-1:0] a);
		return (a == LAST_IDX) ? '0 : a + AW'(1);
	endfunction

	// push side: drop oldest on a full ring, then address of the new entry
	logic                    full;
	logic [AW-1:0]           oldest_eff, wr_addr;
	logic [CW-1:0]           cnt_eff;
	logic [AW:0]             wsum;
	logic                    in_fire;
	logic [dpi_pkg::TIME_W-1:0] elapsed_nxt;
	dpi_pkg::snap_t          wr_entry;

	assign in_fire     = in_ch.valid && in_ch.ready;
	assign full        = (count_q >= DEPTH_C);
	assign oldest_eff  = full ? inc_idx(oldest_q) : oldest_q;
	assign cnt_eff     = full ? (DEPTH_C - CW'(1)) : count_q;
	assign wsum        = {1'b0, oldest_eff} + {1'b0, cnt_eff[AW-1:0]};
	assign wr_addr     = (wsum >= (AW+1)'(HISTORY_DEPTH)) ?
		AW'(wsum - (AW+1)'(HISTORY_DEPTH)) : wsum[AW-1:0];
	assign elapsed_nxt = elapsed_q + dpi_pkg::TIME_W'(in_ch.dt_us);

	always_comb begin
		wr_entry     = '0;
		wr_entry.t   = elapsed_nxt;
		wr_entry.x   = in_ch.pos_x;
		wr_entry.y   = in_ch.pos_y;
		wr_entry.rot = in_ch.rotation_in;
		wr_entry.sx  = in_ch.scale_x_in;
		wr_entry.sy  = in_ch.scale_y_in;
	end

	logic [AW-1:0] rd_addr;
	assign rd_addr = (state_q == S_PRUNE_RD) ? oldest_q : ptr_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mem[wr_addr] <= wr_entry;
		end
		rd_q <= mem[rd_addr];
	end

	// time compares
	logic [dpi_pkg::TIME_W-1:0] delay32, max_age, age_rd, age_prev, gap;
	logic                       bracket;
	assign delay32  = dpi_pkg::TIME_W'(delay_q);
	assign max_age  = delay32 + dpi_pkg::KEEP_EXTRA_US;
	assign age_rd   = elapsed_q - rd_q.t;
	assign age_prev = elapsed_q - prev_q.t;
	assign gap      = age_prev - age_rd;
	assign bracket  = (age_prev >= delay32) && (age_rd <= delay32);

	// lerp datapath
	logic signed [dpi_pkg::POS_W-1:0] fp, fn;
	logic signed [dpi_pkg::POS_W:0]   fd;
	logic [dpi_pkg::ACC_W+1:0]        nval;
	logic [dpi_pkg::REM_W:0]          rem2, dsor;
	logic signed [dpi_pkg::POS_W+1:0] fin;

	assign fp   = dpi_pkg::entry_field(prev_q, fld_q);
	assign fn   = dpi_pkg::entry_field(next_q, fld_q);
	assign fd   = (dpi_pkg::POS_W+1)'(fn) - (dpi_pkg::POS_W+1)'(fp);
	assign nval = {1'b0, acc_q, 1'b0} + (dpi_pkg::ACC_W+2)'(den_q);
	assign rem2 = {rem_q, dvd_q[cnt_q]};
	assign dsor = {1'b0, den_q, 1'b0};
	assign fin  = neg_q ? ((dpi_pkg::POS_W+2)'(p_q) - (dpi_pkg::POS_W+2)'(quo_q))
		: ((dpi_pkg::POS_W+2)'(p_q) + (dpi_pkg::POS_W+2)'(quo_q));

	logic out_load;
	assign out_load = (state_q == S_OUT) && (!ov_q || out_ch.ready);

	always_ff @(posedge clk) begin
		if (state_q == S_PRUNE_CHK) begin
			prev_q  <= rd_q;
			first_q <= rd_q;
		end else if (state_q == S_SCAN_CHK) begin
			if (bracket) begin
				next_q <= rd_q;
			end else begin
				prev_q <= rd_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			delay_q   <= '0;
			elapsed_q <= '0;
			oldest_q  <= '0;
			count_q   <= '0;
			ptr_q     <= '0;
			idx_q     <= '0;
			cnt_q     <= '0;
			fld_q     <= dpi_pkg::FLD_X;
			res_vld_q <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				delay_q <= cfg_wdata;
			end
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						elapsed_q <= elapsed_nxt;
						oldest_q  <= oldest_eff;
						count_q   <= cnt_eff + CW'(1);
						state_q   <= S_PRUNE_RD;
					end
				end
				S_PRUNE_RD: state_q <= S_PRUNE_CHK;
				S_PRUNE_CHK: begin
					if (age_rd > max_age) begin
						oldest_q <= inc_idx(oldest_q);
						count_q  <= count_q - CW'(1);
						state_q  <= S_PRUNE_RD;
					end else if (count_q < CW'(2) || delay32 <= dpi_pkg::MIN_DELAY_US) begin
						for (int k = 0; k < dpi_pkg::NUM_FIELDS; k++) res_q[k] <= '0;
						res_vld_q <= 1'b0;
						state_q   <= S_OUT;
					end else begin
						ptr_q   <= inc_idx(oldest_q);
						idx_q   <= CW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (bracket) begin
						if (gap > dpi_pkg::MIN_GAP_US) begin
							num_q   <= dpi_pkg::NUM_W'(age_prev - delay32);
							den_q   <= dpi_pkg::NUM_W'(gap);
							fld_q   <= dpi_pkg::FLD_X;
							state_q <= S_LERP_SET;
						end else begin
							for (int k = 0; k < dpi_pkg::NUM_FIELDS; k++)
								res_q[k] <= dpi_pkg::entry_field(prev_q, dpi_pkg::fld_t'(k));
							res_vld_q <= 1'b1;
							state_q   <= S_OUT;
						end
					end else if ((idx_q + CW'(1)) < count_q) begin
						idx_q   <= idx_q + CW'(1);
						ptr_q   <= inc_idx(ptr_q);
						state_q <= S_SCAN_RD;
					end else begin
						// no bracketing pair: oldest entry as is
						for (int k = 0; k < dpi_pkg::NUM_FIELDS; k++)
							res_q[k] <= dpi_pkg::entry_field(first_q, dpi_pkg::fld_t'(k));
						res_vld_q <= 1'b1;
						state_q   <= S_OUT;
					end
				end
				S_LERP_SET: begin
					neg_q   <= fd[dpi_pkg::POS_W];
					mag_q   <= fd[dpi_pkg::POS_W] ? dpi_pkg::MAG_W'(-fd)
						: dpi_pkg::MAG_W'(fd);
					p_q     <= fp;
					acc_q   <= '0;
					cnt_q   <= 5'(dpi_pkg::NUM_W - 1);
					state_q <= S_MUL;
				end
				S_MUL: begin
					acc_q <= {acc_q[dpi_pkg::ACC_W-2:0], 1'b0}
						+ (num_q[cnt_q] ? dpi_pkg::ACC_W'(mag_q) : '0);
					if (cnt_q == '0) begin
						state_q <= S_DIV_SET;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				S_DIV_SET: begin
					// round half away: (2*mag*num + den) / (2*den)
					rem_q   <= nval[dpi_pkg::ACC_W+1:dpi_pkg::QUO_W];
					dvd_q   <= nval[dpi_pkg::QUO_W-1:0];
					quo_q   <= '0;
					cnt_q   <= 5'(dpi_pkg::QUO_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (rem2 >= dsor) begin
						rem_q <= dpi_pkg::REM_W'(rem2 - dsor);
						quo_q <= {quo_q[dpi_pkg::QUO_W-2:0], 1'b1};
					end else begin
						rem_q <= rem2[dpi_pkg::REM_W-1:0];
						quo_q <= {quo_q[dpi_pkg::QUO_W-2:0], 1'b0};
					end
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				S_FIN: begin
					res_q[fld_q] <= fin[dpi_pkg::POS_W-1:0];
					if (fld_q == dpi_pkg::FLD_SY) begin
						res_vld_q <= 1'b1;
						state_q   <= S_OUT;
					end else begin
						fld_q   <= dpi_pkg::fld_t'(fld_q + 3'd1);
						state_q <= S_LERP_SET;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			osv_q  <= res_vld_q;
			ox_q   <= res_q[0];
			oy_q   <= res_q[1];
			orot_q <= res_q[2];
			osx_q  <= res_q[3][dpi_pkg::SCL_W-1:0];
			osy_q  <= res_q[4][dpi_pkg::SCL_W-1:0];
		end
	end

	assign in_ch.ready            = (state_q == S_IDLE);
	assign out_ch.valid           = ov_q;
	assign out_ch.shadow_valid    = osv_q;
	assign out_ch.shadow_x        = ox_q;
	assign out_ch.shadow_y        = oy_q;
	assign out_ch.shadow_rotation = orot_q;
	assign out_ch.shadow_scale_x  = osx_q;
	assign out_ch.shadow_scale_y  = osy_q;

endmodule

`default_nettype wire

// ===== design/dpi_checker.sv =====
// ----------------------------------------------------------------------------
// dpi_checker
// Port-level checks for the delayed pose interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dpi_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire                        shadow_valid,
	input wire [dpi_pkg::POS_W-1:0]   shadow_x,
	input wire [dpi_pkg::POS_W-1:0]   shadow_y,
	input wire [dpi_pkg::POS_W-1:0]   shadow_rotation,
	input wire [dpi_pkg::SCL_W-1:0]   shadow_scale_x,
	input wire [dpi_pkg::SCL_W-1:0]   shadow_scale_y
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(shadow_x)
			&& $stable(shadow_valid) && $stable(shadow_scale_y))
		else $error("stalled result changed");

	// an invalid shadow carries a zero pose
	a_zero_pose: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !shadow_valid |-> shadow_x == '0 && shadow_y == '0
			&& shadow_rotation == '0 && shadow_scale_x == '0 && shadow_scale_y == '0)
		else $error("invalid shadow with nonzero pose");

	// one item in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

endmodule

bind delayed_pose_interpolator dpi_checker u_dpi_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.shadow_valid    (out_ch.shadow_valid),
	.shadow_x        (out_ch.shadow_x),
	.shadow_y        (out_ch.shadow_y),
	.shadow_rotation (out_ch.shadow_rotation),
	.shadow_scale_x  (out_ch.shadow_scale_x),
	.shadow_scale_y  (out_ch.shadow_scale_y)
);

`default_nettype wire
